### hw/rtl/packet_header_filter_defines.svh
// Assertion helpers used by the checker file of the frame filter.
`ifndef PACKET_HEADER_FILTER_DEFINES_SVH
`define PACKET_HEADER_FILTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle, ignored while in reset.
`define PHF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phf assertion failed");

// Antecedent implies consequent in the next cycle, ignored while in reset.
`define PHF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phf assertion failed");

// Checked at every edge, reset included.
`define PHF_ASSERT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("phf assertion failed");

`endif

### hw/rtl/phf_pkg.sv
`default_nettype none

package phf_pkg;

    localparam int MAX_FRAME = 8192;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 14;

    localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_FRAME);
    localparam logic [POS_W-1:0] POS_IHL   = POS_W'(14);
    localparam logic [POS_W-1:0] POS_TYPE_HI = POS_W'(12);
    localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_PROTO = POS_W'(23);
    localparam logic [POS_W-1:0] IP_SRC    = POS_W'(26);
    localparam logic [POS_W-1:0] IP_DST    = POS_W'(30);
    localparam logic [POS_W-1:0] ARP_SPA   = POS_W'(28);
    localparam logic [POS_W-1:0] ARP_TPA   = POS_W'(38);

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Bits of show_mask.
    localparam int SHOW_ETHER = 0;
    localparam int SHOW_ARP   = 1;
    localparam int SHOW_IP    = 2;
    localparam int SHOW_TCP   = 3;
    localparam int SHOW_UDP   = 4;
    localparam int SHOW_ICMP  = 5;
    localparam int SHOW_ALL   = 6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_MASK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_FILTER_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ADDR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_FILTER_ON = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_PORT    = 3'd4;

    typedef enum logic [2:0] {
        CLS_ARP      = 3'd0,
        CLS_TCP      = 3'd1,
        CLS_UDP      = 3'd2,
        CLS_ICMP     = 3'd3,
        CLS_IP_OTHER = 3'd4,
        CLS_OTHER    = 3'd5
    } t_class;

    typedef struct packed {
        logic [6:0]  show_mask;
        logic        addr_filter_on;
        logic [31:0] filter_addr;
        logic        port_filter_on;
        logic [15:0] filter_port;
    } t_cfg;

    // What the parser hands over for one finished frame.
    typedef struct packed {
        logic [POS_W-1:0] len;
        t_class           cls;
        logic             is_arp;
        logic [3:0]       header_words;
        logic             first_hit;
        logic             second_hit;
        logic [15:0]      port_shift;
        logic             src_hit;
        logic             dst_hit;
    } t_summary;

    typedef struct packed {
        logic             shown;
        logic             dropped;
        t_class           cls;
        logic [LEN_W-1:0] len;
    } t_result;

    // Byte k of the filter address, byte 0 being the first on the wire.
    function automatic logic [7:0] addr_byte(input logic [31:0] addr, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = addr[31:24];
            2'd1:    b = addr[23:16];
            2'd2:    b = addr[15:8];
            default: b = addr[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/phf_front.sv
`default_nettype none

module phf_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_last,
    input  wire logic                  i_q_full,
    input  wire phf_pkg::t_cfg         i_cfg,
    output logic                       o_ready,
    output logic                       o_push,
    output phf_pkg::t_summary          o_summary
);

    logic [phf_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0]               r_kind, n_kind;
    logic [3:0]                r_hw, n_hw;
    logic [7:0]                r_proto, n_proto;
    logic                      r_first_hit, n_first_hit;
    logic                      r_second_hit, n_second_hit;
    logic [15:0]               r_port, n_port;
    logic                      r_src_hit, n_src_hit;
    logic                      r_dst_hit, n_dst_hit;

    logic                      accept;
    logic                      in_range;
    logic [3:0]                hw;
    logic [phf_pkg::POS_W-1:0] start1, start2, off1, off2, t_pos;
    logic                      addr_region;
    logic [15:0]               port_or;
    logic                      is_arp, is_ip;
    phf_pkg::t_class           cls;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign in_range = r_pos < phf_pkg::MAX_POS;
    assign hw       = (r_pos == phf_pkg::POS_IHL) ? i_byte[3:0] : r_hw;
    assign t_pos    = phf_pkg::POS_IHL + phf_pkg::POS_W'({hw, 2'b00});
    assign port_or  = r_port | {8'h00, i_byte};

    // Address regions depend on the ethertype, which is settled long before them.
    always_comb begin
        addr_region = 1'b0;
        start1      = phf_pkg::IP_SRC;
        start2      = phf_pkg::IP_DST;
        if (r_kind == phf_pkg::ETH_IPV4) begin
            addr_region = 1'b1;
        end else if (r_kind == phf_pkg::ETH_ARP) begin
            addr_region = 1'b1;
            start1      = phf_pkg::ARP_SPA;
            start2      = phf_pkg::ARP_TPA;
        end
        off1 = r_pos - start1;
        off2 = r_pos - start2;
    end

    always_comb begin
        n_pos        = r_pos;
        n_kind       = r_kind;
        n_hw         = r_hw;
        n_proto      = r_proto;
        n_first_hit  = r_first_hit;
        n_second_hit = r_second_hit;
        n_port       = r_port;
        n_src_hit    = r_src_hit;
        n_dst_hit    = r_dst_hit;

        if (accept && in_range) begin
            if (r_pos == phf_pkg::POS_TYPE_HI) begin
                n_kind = {i_byte, 8'h00};
            end
            if (r_pos == phf_pkg::POS_TYPE_LO) begin
                n_kind = r_kind | {8'h00, i_byte};
            end
            n_hw = hw;
            if (r_pos == phf_pkg::POS_PROTO) begin
                n_proto = i_byte;
            end
            if (addr_region) begin
                if (r_pos >= start1 && off1 < phf_pkg::POS_W'(4) &&
                    i_byte != phf_pkg::addr_byte(i_cfg.filter_addr, off1[1:0])) begin
                    n_first_hit = 1'b0;
                end
                if (r_pos >= start2 && off2 < phf_pkg::POS_W'(4) &&
                    i_byte != phf_pkg::addr_byte(i_cfg.filter_addr, off2[1:0])) begin
                    n_second_hit = 1'b0;
                end
            end
            if (r_pos >= phf_pkg::POS_IHL) begin
                if (r_pos == t_pos || r_pos == t_pos + phf_pkg::POS_W'(2)) begin
                    n_port = {i_byte, 8'h00};
                end
                if (r_pos == t_pos + phf_pkg::POS_W'(1)) begin
                    n_port    = port_or;
                    n_src_hit = (port_or == i_cfg.filter_port);
                end
                if (r_pos == t_pos + phf_pkg::POS_W'(3)) begin
                    n_port    = port_or;
                    n_dst_hit = (port_or == i_cfg.filter_port);
                end
            end
            n_pos = r_pos + phf_pkg::POS_W'(1);
        end
    end

    always_comb begin
        is_arp = (n_kind == phf_pkg::ETH_ARP);
        is_ip  = (n_kind == phf_pkg::ETH_IPV4);
        if (is_arp) begin
            cls = phf_pkg::CLS_ARP;
        end else if (!is_ip) begin
            cls = phf_pkg::CLS_OTHER;
        end else if (n_proto == phf_pkg::PROTO_TCP) begin
            cls = phf_pkg::CLS_TCP;
        end else if (n_proto == phf_pkg::PROTO_UDP) begin
            cls = phf_pkg::CLS_UDP;
        end else if (n_proto == phf_pkg::PROTO_ICMP) begin
            cls = phf_pkg::CLS_ICMP;
        end else begin
            cls = phf_pkg::CLS_IP_OTHER;
        end
    end

    assign o_push                 = accept && i_last;
    assign o_summary.len          = n_pos;
    assign o_summary.cls          = cls;
    assign o_summary.is_arp       = is_arp;
    assign o_summary.header_words = n_hw;
    assign o_summary.first_hit    = n_first_hit;
    assign o_summary.second_hit   = n_second_hit;
    assign o_summary.port_shift   = n_port;
    assign o_summary.src_hit      = n_src_hit;
    assign o_summary.dst_hit      = n_dst_hit;

    // The last byte of a frame hands off the summary and starts the next frame clean.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos        <= '0;
            r_kind       <= '0;
            r_hw         <= '0;
            r_proto      <= '0;
            r_first_hit  <= 1'b1;
            r_second_hit <= 1'b1;
            r_port       <= '0;
            r_src_hit    <= 1'b0;
            r_dst_hit    <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_kind       <= n_kind;
            r_hw         <= n_hw;
            r_proto      <= n_proto;
            r_first_hit  <= n_first_hit;
            r_second_hit <= n_second_hit;
            r_port       <= n_port;
            r_src_hit    <= n_src_hit;
            r_dst_hit    <= n_dst_hit;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/phf_queue.sv
`default_nettype none

module phf_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire phf_pkg::t_summary i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output phf_pkg::t_summary      o_data
);

    phf_pkg::t_summary r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/phf_back.sv
`default_nettype none

module phf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire phf_pkg::t_summary i_summary,
    input  wire phf_pkg::t_cfg     i_cfg,
    input  wire logic              i_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output phf_pkg::t_result       o_result
);

    logic                      r_valid;
    phf_pkg::t_result          r_result, n_result;

    logic [phf_pkg::POS_W-1:0] a1, a2, t_pos, len;
    logic                      a_hit, s_hit, d_hit, p_hit;
    logic                      o_ip, o_tcp, o_udp, o_icmp, o_arp, o_all, disp;
    logic                      is_tcp_udp;

    // Address bytes cut off by a short frame read as zero.
    function automatic logic tail_ok(input logic [phf_pkg::POS_W-1:0] start,
                                     input logic [phf_pkg::POS_W-1:0] flen,
                                     input logic [31:0] addr);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (start + phf_pkg::POS_W'(k) >= flen &&
                phf_pkg::addr_byte(addr, 2'(k)) != 8'h00) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb begin
        len   = i_summary.len;
        a1    = i_summary.is_arp ? phf_pkg::ARP_SPA : phf_pkg::IP_SRC;
        a2    = i_summary.is_arp ? phf_pkg::ARP_TPA : phf_pkg::IP_DST;
        a_hit = (i_summary.first_hit && tail_ok(a1, len, i_cfg.filter_addr)) ||
                (i_summary.second_hit && tail_ok(a2, len, i_cfg.filter_addr)) ||
                !i_cfg.addr_filter_on;

        // A port whose bytes ran past the end of the frame is judged on what arrived.
        t_pos = phf_pkg::POS_IHL + phf_pkg::POS_W'({i_summary.header_words, 2'b00});
        if (len >= t_pos + phf_pkg::POS_W'(2)) begin
            s_hit = i_summary.src_hit;
        end else begin
            s_hit = (i_summary.port_shift == i_cfg.filter_port);
        end
        if (len >= t_pos + phf_pkg::POS_W'(4)) begin
            d_hit = i_summary.dst_hit;
        end else if (len == t_pos + phf_pkg::POS_W'(3)) begin
            d_hit = (i_summary.port_shift == i_cfg.filter_port);
        end else begin
            d_hit = (i_cfg.filter_port == 16'h0000);
        end
        p_hit = !i_cfg.port_filter_on || s_hit || d_hit;

        o_arp  = i_cfg.show_mask[phf_pkg::SHOW_ARP];
        o_ip   = i_cfg.show_mask[phf_pkg::SHOW_IP];
        o_tcp  = i_cfg.show_mask[phf_pkg::SHOW_TCP];
        o_udp  = i_cfg.show_mask[phf_pkg::SHOW_UDP];
        o_icmp = i_cfg.show_mask[phf_pkg::SHOW_ICMP];
        o_all  = i_cfg.show_mask[phf_pkg::SHOW_ALL];

        is_tcp_udp = (i_summary.cls == phf_pkg::CLS_TCP) ||
                     (i_summary.cls == phf_pkg::CLS_UDP);
        disp = o_ip && !o_tcp && !o_udp && !o_icmp;
        case (i_summary.cls)
            phf_pkg::CLS_TCP:      disp = disp || o_tcp;
            phf_pkg::CLS_UDP:      disp = disp || o_udp;
            phf_pkg::CLS_ICMP:     disp = disp || o_icmp;
            default:               disp = disp || o_all;
        endcase

        n_result.cls     = i_summary.cls;
        n_result.len     = phf_pkg::LEN_W'(len);
        n_result.shown   = 1'b0;
        n_result.dropped = 1'b0;
        if (i_summary.cls == phf_pkg::CLS_ARP) begin
            n_result.dropped = !a_hit;
            n_result.shown   = (o_arp && a_hit) || o_all;
        end else if (i_summary.cls == phf_pkg::CLS_OTHER) begin
            n_result.shown = o_all;
        end else if (!a_hit || (is_tcp_udp && !p_hit)) begin
            n_result.dropped = 1'b1;
        end else begin
            n_result.shown = disp || o_all;
        end
    end

    // A queued result is loaded when the output register is empty or being drained.
    assign o_pop    = !i_q_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/packet_header_filter.sv
// Ethernet frame classifier and address/port filter.
// Frame bytes enter on the s_axis channel, one byte per transfer, starting at the
// destination MAC; tlast marks the final byte. For each frame one verdict leaves on
// the m_axis channel: shown, dropped, frame class and frame length.
// The cfg channel writes show_mask (0), addr_filter_on (1), filter_addr (2),
// port_filter_on (3) and filter_port (4); it is always ready and should be used
// between frames.
// Throughput is one byte per clock while s_axis_tready is high: the byte parser
// updates its header state in the cycle of each transfer. After the last byte is
// transferred, the parser writes a frame summary into a two-entry queue, and the
// decision stage takes it from there and turns it into the registered result.
// When the receiver stalls, the result holds and up to two further frame summaries
// wait in the queue; s_axis_tready drops only when that queue is full.
// A synchronous active-low reset clears the parser, the queue and the output valid,
// and loads the register defaults (show_mask 62, filters off, address and port 0).
`default_nettype none

module packet_header_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,  // [7:0] frame_byte
    input  wire logic                           i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [0] shown, [1] dropped, [4:2] frame_class, [18:5] frame_length, [23:19] zero
    output logic [23:0]                         o_m_axis_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [phf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);

    phf_pkg::t_cfg     r_cfg;
    phf_pkg::t_summary push_data, q_data;
    phf_pkg::t_result  result;
    logic              push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.show_mask      <= 7'd62;
            r_cfg.addr_filter_on <= 1'b0;
            r_cfg.filter_addr    <= 32'h0000_0000;
            r_cfg.port_filter_on <= 1'b0;
            r_cfg.filter_port    <= 16'h0000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                phf_pkg::CFG_SHOW_MASK:      r_cfg.show_mask      <= i_cfg_data[6:0];
                phf_pkg::CFG_ADDR_FILTER_ON: r_cfg.addr_filter_on <= i_cfg_data[0];
                phf_pkg::CFG_FILTER_ADDR:    r_cfg.filter_addr    <= i_cfg_data;
                phf_pkg::CFG_PORT_FILTER_ON: r_cfg.port_filter_on <= i_cfg_data[0];
                phf_pkg::CFG_FILTER_PORT:    r_cfg.filter_port    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    phf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_q_full  (q_full),
        .i_cfg     (r_cfg),
        .o_ready   (o_s_axis_tready),
        .o_push    (push),
        .o_summary (push_data)
    );

    phf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    phf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_summary (q_data),
        .i_cfg     (r_cfg),
        .i_ready   (i_m_axis_tready),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {5'b00000, result.len, result.cls, result.dropped, result.shown};

endmodule

`default_nettype wire

### hw/rtl/phf_checker.sv
`default_nettype none
`include "packet_header_filter_defines.svh"

module phf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] i_m_tdata
);

    // No verdict may be pending right after a reset cycle.
    `PHF_ASSERT_ANY(a_reset_clears_out, i_clk, $past(!i_rst_n), !i_m_tvalid)

    // A stalled verdict stays put.
    `PHF_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))

    // Only six frame classes exist.
    `PHF_ASSERT_IMP(a_class_range, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[4:2] <= phf_pkg::CLS_OTHER)

    // Outside ARP a frame rejected by a filter is never shown; show all can still show ARP.
    `PHF_ASSERT_IMP(a_drop_not_shown, i_clk, i_rst_n, i_m_tvalid && i_m_tdata[1] && i_m_tdata[4:2] != phf_pkg::CLS_ARP, !i_m_tdata[0])

endmodule

bind packet_header_filter phf_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire

### tb/packet_header_filter_tb.sv
`timescale 1ns / 1ps

module packet_header_filter_tb;
    import phf_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata;   // [7:0] frame_byte
    logic                 i_s_axis_tlast;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // [0] shown, [1] dropped, [4:2] frame_class, [18:5] frame_length, [23:19] zero
    logic [23:0]          o_m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    packet_header_filter dut (.*);

    // Predicts the verdict of every frame from the bytes and register writes that
    // were actually transferred, and checks the verdicts that come out in order.
    class frame_verdict_model;
        logic [6:0]  show_mask;
        logic        addr_on;
        logic [31:0] match_addr;
        logic        port_on;
        logic [15:0] match_port;

        int          pos_cnt;
        logic [15:0] ether_kind;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        bit          first_hit;
        bit          second_hit;
        logic [15:0] port_sr;
        bit          src_hit;
        bit          dst_hit;

        t_result     expected_verdicts[$];
        int          mismatches;
        int          verdicts_checked;

        function new();
            show_mask = 7'd62;
            addr_on = 1'b0;
            match_addr = '0;
            port_on = 1'b0;
            match_port = '0;
            mismatches = 0;
            verdicts_checked = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos_cnt = 0;
            ether_kind = '0;
            ihl = '0;
            proto = '0;
            first_hit = 1'b1;
            second_hit = 1'b1;
            port_sr = '0;
            src_hit = 1'b0;
            dst_hit = 1'b0;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_SHOW_MASK:      show_mask = val[6:0];
                CFG_ADDR_FILTER_ON: addr_on = val[0];
                CFG_FILTER_ADDR:    match_addr = val;
                CFG_PORT_FILTER_ON: port_on = val[0];
                CFG_FILTER_PORT:    match_port = val[15:0];
                default: ;
            endcase
        endfunction

        // Byte k of the filter address in wire order.
        function logic [7:0] filter_byte(int k);
            return match_addr[31 - 8 * k -: 8];
        endfunction

        function bit addr_miss(int pos, int start, logic [7:0] b);
            return pos >= start && pos < start + 4 && b != filter_byte(pos - start);
        endfunction

        // Address bytes that never arrived count as zero.
        function bit tail_ok(int start, int len);
            for (int k = 0; k < 4; k++)
                if (start + k >= len && filter_byte(k) != 8'h00)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int       pos;
            int       len;
            int       t;
            int       a_start;
            int       b_start;
            logic [3:0] hw;
            bit       a_hit;
            bit       s_hit;
            bit       d_hit;
            bit       p_hit;
            bit       disp;
            t_result  v;

            pos = pos_cnt;
            if (pos < MAX_FRAME) begin
                hw = (pos == POS_IHL) ? b[3:0] : ihl;
                if (pos == POS_TYPE_HI) ether_kind = {b, 8'h00};
                if (pos == POS_TYPE_LO) ether_kind = ether_kind | {8'h00, b};
                if (pos == POS_IHL) ihl = hw;
                if (pos == POS_PROTO) proto = b;
                if (ether_kind == ETH_IPV4) begin
                    if (addr_miss(pos, IP_SRC, b)) first_hit = 1'b0;
                    if (addr_miss(pos, IP_DST, b)) second_hit = 1'b0;
                end else if (ether_kind == ETH_ARP) begin
                    if (addr_miss(pos, ARP_SPA, b)) first_hit = 1'b0;
                    if (addr_miss(pos, ARP_TPA, b)) second_hit = 1'b0;
                end
                if (pos >= POS_IHL) begin
                    t = POS_IHL + 4 * hw;
                    if (pos == t || pos == t + 2) port_sr = {b, 8'h00};
                    if (pos == t + 1) begin
                        port_sr = port_sr | {8'h00, b};
                        src_hit = (port_sr == match_port);
                    end
                    if (pos == t + 3) begin
                        port_sr = port_sr | {8'h00, b};
                        dst_hit = (port_sr == match_port);
                    end
                end
                pos_cnt = pos + 1;
            end
            if (!last)
                return;

            len = pos_cnt;
            a_start = (ether_kind == ETH_ARP) ? ARP_SPA : IP_SRC;
            b_start = (ether_kind == ETH_ARP) ? ARP_TPA : IP_DST;
            a_hit = (first_hit && tail_ok(a_start, len)) || (second_hit && tail_ok(b_start, len));
            if (!addr_on) a_hit = 1'b1;

            // A port cut short by the end of the frame is compared as far as it got.
            t = POS_IHL + 4 * ihl;
            s_hit = (len >= t + 2) ? src_hit : (port_sr == match_port);
            if (len >= t + 4) d_hit = dst_hit;
            else if (len == t + 3) d_hit = (port_sr == match_port);
            else d_hit = (match_port == 16'h0000);
            p_hit = !port_on || s_hit || d_hit;

            v.shown = 1'b0;
            v.dropped = 1'b0;
            v.len = 14'(len);
            if (ether_kind == ETH_ARP) begin
                v.cls = CLS_ARP;
                v.dropped = !a_hit;
                v.shown = (show_mask[SHOW_ARP] && a_hit) || show_mask[SHOW_ALL];
            end else if (ether_kind == ETH_IPV4) begin
                disp = show_mask[SHOW_IP] && !show_mask[SHOW_TCP] && !show_mask[SHOW_UDP]
                       && !show_mask[SHOW_ICMP];
                case (proto)
                    PROTO_TCP: begin
                        v.cls = CLS_TCP;
                        disp = disp || show_mask[SHOW_TCP];
                    end
                    PROTO_UDP: begin
                        v.cls = CLS_UDP;
                        disp = disp || show_mask[SHOW_UDP];
                    end
                    PROTO_ICMP: begin
                        v.cls = CLS_ICMP;
                        disp = disp || show_mask[SHOW_ICMP];
                    end
                    default: begin
                        v.cls = CLS_IP_OTHER;
                        disp = disp || show_mask[SHOW_ALL];
                    end
                endcase
                if (!a_hit || ((v.cls == CLS_TCP || v.cls == CLS_UDP) && !p_hit))
                    v.dropped = 1'b1;
                else
                    v.shown = disp || show_mask[SHOW_ALL];
            end else begin
                // The ether bit alone never shows a frame; show all does.
                v.cls = CLS_OTHER;
                v.shown = show_mask[SHOW_ALL];
            end
            expected_verdicts.push_back(v);
            clear_frame();
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t: verdict %0d %s expected %0h got %0h",
                     $time, verdicts_checked, field, want, got);
        endfunction

        function void check_verdict(logic [23:0] data);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: verdict expected none got %0h", $time, data);
                return;
            end
            want = expected_verdicts.pop_front();
            if (data[0] !== want.shown) report("shown", want.shown, data[0]);
            if (data[1] !== want.dropped) report("dropped", want.dropped, data[1]);
            if (data[4:2] !== want.cls) report("frame_class", want.cls, data[4:2]);
            if (data[18:5] !== want.len) report("frame_length", want.len, data[18:5]);
            if (data[23:19] !== 5'd0) report("padding", 0, data[23:19]);
            verdicts_checked++;
        endfunction
    endclass

    frame_verdict_model board;
    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] cur_addr;
    logic [15:0] cur_port;
    int          frames_sent;
    int          bytes_sent;
    int          settings_used;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.take_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_verdict(o_m_axis_tdata);
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Builds a frame of random bytes with the given header fields laid over it.
    // The ports go in first so that header fields win where they overlap.
    task automatic send_built(input int len, input logic [15:0] etype, input logic [7:0] vihl,
                              input logic [7:0] proto, input logic [31:0] addr_a,
                              input logic [31:0] addr_b, input logic [15:0] sport,
                              input logic [15:0] dport);
        logic [7:0] fb[];
        int         t;
        int         sa;
        int         da;
        fb = new[(len > 128) ? len : 128];
        foreach (fb[i]) fb[i] = 8'($urandom);
        t = POS_IHL + 4 * vihl[3:0];
        {fb[t], fb[t+1], fb[t+2], fb[t+3]} = {sport, dport};
        fb[POS_TYPE_HI] = etype[15:8];
        fb[POS_TYPE_LO] = etype[7:0];
        fb[POS_IHL] = vihl;
        fb[POS_PROTO] = proto;
        sa = (etype == ETH_ARP) ? ARP_SPA : IP_SRC;
        da = (etype == ETH_ARP) ? ARP_TPA : IP_DST;
        {fb[sa], fb[sa+1], fb[sa+2], fb[sa+3]} = addr_a;
        {fb[da], fb[da+1], fb[da+2], fb[da+3]} = addr_b;
        for (int i = 0; i < len; i++)
            send_byte(fb[i], i == len - 1);
        frames_sent++;
        bytes_sent += len;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Waits until the last transfer is noted, then for every verdict, then lets the
    // pipeline settle.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] mask, input logic aon, input logic [31:0] addr,
                             input logic pon, input logic [15:0] port);
        wait_idle();
        write_reg(CFG_SHOW_MASK, 32'(mask));
        write_reg(CFG_ADDR_FILTER_ON, 32'(aon));
        write_reg(CFG_FILTER_ADDR, addr);
        write_reg(CFG_PORT_FILTER_ON, 32'(pon));
        write_reg(CFG_FILTER_PORT, 32'(port));
        i_cfg_valid <= 1'b0;
        cur_addr = addr;
        cur_port = port;
        settings_used++;
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        int          r;
        r = $urandom_range(0, 9);
        a = (r < 6) ? cur_addr : $urandom;
        if (r >= 4 && r < 6) a[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
        return a;
    endfunction

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 9) < 4) ? cur_port : 16'($urandom);
    endfunction

    // Mostly well-formed IPv4 and ARP headers, cut short now and then, with
    // addresses and ports that often hit the current filters.
    task automatic send_random_frame();
        logic [15:0] etype;
        logic [7:0]  vihl;
        logic [7:0]  proto;
        int          full;
        int          len;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 55) etype = ETH_IPV4;
        else if (r < 75) etype = ETH_ARP;
        else if (r < 88) etype = 16'($urandom);
        else etype = ETH_IPV4 ^ (16'h1 << $urandom_range(0, 15));
        vihl = 8'($urandom);
        if ($urandom_range(0, 2) != 0) vihl[3:0] = 4'd5;
        r = $urandom_range(0, 99);
        if (r < 35) proto = PROTO_TCP;
        else if (r < 65) proto = PROTO_UDP;
        else if (r < 80) proto = PROTO_ICMP;
        else proto = 8'($urandom);
        full = POS_IHL + 4 * vihl[3:0] + 4;
        if (full < 42) full = 42;
        if ($urandom_range(0, 99) < 60) len = full + $urandom_range(0, 8);
        else len = $urandom_range(1, full);
        send_built(len, etype, vihl, proto, pick_addr(), pick_addr(), pick_port(), pick_port());
    endtask

    initial begin
        int start_frames;
        int start_bytes;
        board = new();
        send_idle_pct = 0;
        stall_pct = 0;
        cur_addr = '0;
        cur_port = '0;
        frames_sent = 0;
        bytes_sent = 0;
        settings_used = 0;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tlast <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames, first with the register defaults left from reset.
        set_idle(0);
        send_built(1, 16'hFFFF, 8'h45, PROTO_TCP, '0, '0, '0, '0);
        send_built(60, ETH_IPV4, 8'h45, PROTO_TCP, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, PROTO_ICMP, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, 8'h00, '0, '0, '0, '0);
        send_built(60, ETH_IPV4, 8'hFF, 8'hFF, '1, '1, '1, '1);
        send_built(60, ETH_ARP, 8'h00, 8'h00, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(64, 16'h86DD, 8'h60, PROTO_TCP, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        // Header length zero puts the ports on top of the IPv4 header.
        send_built(40, ETH_IPV4, 8'h40, PROTO_TCP, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        // Longer than the maximum frame: the tail is ignored and the length saturates.
        send_built(MAX_FRAME + 8, ETH_IPV4, 8'h45, PROTO_UDP, '0, '0, '0, '0);
        send_built(24, ETH_IPV4, 8'h45, PROTO_TCP, '0, '0, '0, '0);
        send_built(13, ETH_IPV4, 8'h45, PROTO_TCP, '0, '0, '0, '0);

        configure(7'h7F, 1'b1, 32'h0A00_0000, 1'b1, 16'h0050);
        send_built(60, ETH_IPV4, 8'h45, PROTO_TCP, 32'h0A00_0000, $urandom, 16'h0050,
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, PROTO_UDP, 32'h0B0B_0B0B, 32'h0B0B_0B0B, 16'h0050,
                   16'h0050);
        send_built(60, ETH_IPV4, 8'h45, PROTO_TCP, $urandom, 32'h0A00_0000, 16'h1234, 16'h4321);
        // Ends inside the source address; the missing bytes match the zero filter bytes.
        send_built(28, ETH_IPV4, 8'h45, PROTO_ICMP, 32'h0A00_1234, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_ARP, 8'h45, 8'h00, $urandom, 32'h0A00_0000, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_ARP, 8'h45, 8'h00, 32'h0A00_0001, 32'h0B00_0000, 16'($urandom),
                   16'($urandom));
        // Ends one byte into the destination port.
        send_built(37, ETH_IPV4, 8'h45, PROTO_UDP, 32'h0A00_0000, $urandom, 16'h1111, 16'h0050);

        configure(7'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_built(60, ETH_ARP, 8'h45, 8'h00, 32'hFFFF_FFFF, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, PROTO_ICMP, $urandom, 32'hFFFF_FFFF, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, PROTO_TCP, 32'hFFFF_FFFF, $urandom, 16'hFFFF,
                   16'($urandom));

        configure(7'h04, 1'b0, 32'h0000_0000, 1'b0, 16'h0000);
        send_built(60, ETH_IPV4, 8'h45, 8'h2F, $urandom, $urandom, 16'($urandom),
                   16'($urandom));
        send_built(60, ETH_IPV4, 8'h45, PROTO_TCP, $urandom, $urandom, 16'($urandom),
                   16'($urandom));

        // Random frames, one setting and one idling pattern per phase.
        for (int p = 0; p < 8; p++) begin
            configure((p == 0) ? 7'h7F : (p == 1) ? 7'h00 : 7'($urandom),
                      (p < 2) ? 1'b1 : 1'($urandom),
                      (p == 2) ? 32'hFFFF_FFFF : (p == 3) ? 32'h0 :
                          ($urandom & {{8{$urandom_range(0, 3) != 0}},
                                       {8{$urandom_range(0, 3) != 0}},
                                       {8{$urandom_range(0, 3) != 0}},
                                       {8{$urandom_range(0, 3) != 0}}}),
                      (p < 2) ? 1'b1 : 1'($urandom),
                      (p == 4) ? 16'hFFFF : (p == 5) ? 16'h0 : 16'($urandom));
            set_idle(p % 4);
            start_frames = frames_sent;
            start_bytes = bytes_sent;
            while (frames_sent - start_frames < 8 || bytes_sent - start_bytes < 95)
                send_random_frame();
        end

        wait_idle();
        $display("Sent %0d frames (%0d bytes) under %0d register settings and four idling",
                 frames_sent, bytes_sent, settings_used + 1);
        $display("patterns; %0d verdicts checked.", board.verdicts_checked);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Timeout with %0d verdicts outstanding", board.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/phf_pkg.sv
hw/rtl/phf_front.sv
hw/rtl/phf_queue.sv
hw/rtl/phf_back.sv
hw/rtl/packet_header_filter.sv
hw/rtl/phf_checker.sv
tb/packet_header_filter_tb.sv
